@@ src/bni_pkg.sv @@
// ----------------------------------------------------------------------------
// bni_pkg
// shared constants, types and tables of the bayer neighbor interpolation block
// ----------------------------------------------------------------------------
package bni_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int MAX_SEARCH_DEF = 8;

    localparam int SAMPLE_W = 16;
    localparam int CODE_W   = 2;
    localparam int POS_W    = 6;
    localparam int DIM_W    = 7;
    localparam int COORD_W  = 8;
    localparam int STEP_W   = 5;
    localparam int IDX_W    = 3;
    localparam int SUM_W    = 18;
    localparam int CNT_W    = 3;
    localparam int WGT_W    = 20;
    localparam int PROD_W   = 36;
    localparam int NUM_W    = 39;
    localparam int DEN_W    = 23;
    localparam int DCNT_W   = 6;
    localparam int STATE_W  = 4;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_SEARCH_STEPS = 3'd2;
    localparam logic [2:0] REG_CODE_COLOR_0 = 3'd3;
    localparam logic [2:0] REG_CODE_COLOR_1 = 3'd4;
    localparam logic [2:0] REG_CODE_COLOR_2 = 3'd5;
    localparam logic [2:0] REG_CODE_COLOR_3 = 3'd6;

    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] COLOR_BLUE = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic [3:0]       search_steps;
        logic [1:0]       code_color_0;
        logic [1:0]       code_color_1;
        logic [1:0]       code_color_2;
        logic [1:0]       code_color_3;
    } cfg_t;

    typedef struct packed {
        logic write;
        logic load;
        logic all_zero;
        logic clr_init;
        logic clr_next;
        logic read;
        logic nb_acc;
        logic nb_next;
        logic div_avg;
        logic dir_init;
        logic dir_step;
        logic dir_next;
        logic mul;
        logic acc;
        logic div_wgt;
        logic div_step;
        logic div_store;
        logic zero_res;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic outside;
        logic in_frame;
        logic match;
        logic nb_last;
        logic dir_last;
        logic cnt_zero;
        logic den_zero;
        logic step_over;
        logic div_last;
        logic clr_last;
    } dp_status_t;

    function automatic logic [WGT_W-1:0] step_weight(input logic [STEP_W-1:0] d);
        logic [WGT_W-1:0] w;
        case (d)
            5'd1:    w = 20'd720720;
            5'd2:    w = 20'd360360;
            5'd3:    w = 20'd240240;
            5'd4:    w = 20'd180180;
            5'd5:    w = 20'd144144;
            5'd6:    w = 20'd120120;
            5'd7:    w = 20'd102960;
            5'd8:    w = 20'd90090;
            5'd9:    w = 20'd80080;
            5'd10:   w = 20'd72072;
            5'd11:   w = 20'd65520;
            5'd12:   w = 20'd60060;
            5'd13:   w = 20'd55440;
            5'd14:   w = 20'd51480;
            5'd15:   w = 20'd48048;
            5'd16:   w = 20'd45045;
            default: w = '0;
        endcase
        return w;
    endfunction

    // order: right, left, down, up, down-right, down-left, up-right, up-left
    function automatic logic signed [COORD_W-1:0] dir_dc(input logic [IDX_W-1:0] i);
        logic signed [COORD_W-1:0] d;
        case (i)
            3'd0, 3'd4, 3'd6: d = 8'sd1;
            3'd1, 3'd5, 3'd7: d = -8'sd1;
            default:          d = 8'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [COORD_W-1:0] dir_dr(input logic [IDX_W-1:0] i);
        logic signed [COORD_W-1:0] d;
        case (i)
            3'd2, 3'd4, 3'd5: d = 8'sd1;
            3'd3, 3'd6, 3'd7: d = -8'sd1;
            default:          d = 8'sd0;
        endcase
        return d;
    endfunction

endpackage

@@ src/bayer_neighbor_interpolation.sv @@
// ----------------------------------------------------------------------------
// bayer_neighbor_interpolation
// bayer frame store with per-pixel rgb interpolation on query
// ----------------------------------------------------------------------------
// A store beat is written into the frame memory while the block stays idle.
// A query outside the active frame returns an all-zero result without any
// memory reads. Any other query runs three color passes. Each pass starts
// with a neighbor pass of up to four memory reads, one per in-frame pixel,
// through the check, read, evaluate and next states. It then takes either a
// restoring divide, or a search in eight directions followed by the same
// divide, or a zero result when the search matched no pixel. The search
// probes up to search_steps pixels per direction. The frame memory has a
// single read port and the divider is bit-serial, one quotient bit per step.
// Frame memory has no reset; query only pixels that were stored.
module bayer_neighbor_interpolation #(
    parameter int MAX_WIDTH  = bni_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bni_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_SEARCH = bni_pkg::MAX_SEARCH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // pos_col, pos_row, raw_value, filter_code
    input  logic                          s_tuser,  // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [47:0]                   m_tdata,  // red_value, green_value, blue_value
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bni_pkg::PADDR_W-1:0]   paddr,
    input  logic [bni_pkg::PDATA_W-1:0]   pwdata,
    output logic [bni_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    bni_pkg::cfg_t       cfg_reg;
    bni_pkg::ctrl_cmd_t  cmd;
    bni_pkg::dp_status_t status;
    logic [2:0]          reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= 7'd64;
            cfg_reg.frame_height <= 7'd64;
            cfg_reg.search_steps <= 4'd4;
            cfg_reg.code_color_0 <= 2'd0;
            cfg_reg.code_color_1 <= 2'd1;
            cfg_reg.code_color_2 <= 2'd1;
            cfg_reg.code_color_3 <= 2'd2;
        end else if (wr_en) begin
            case (reg_idx)
                bni_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[6:0];
                bni_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[6:0];
                bni_pkg::REG_SEARCH_STEPS: cfg_reg.search_steps <= pwdata[3:0];
                bni_pkg::REG_CODE_COLOR_0: cfg_reg.code_color_0 <= pwdata[1:0];
                bni_pkg::REG_CODE_COLOR_1: cfg_reg.code_color_1 <= pwdata[1:0];
                bni_pkg::REG_CODE_COLOR_2: cfg_reg.code_color_2 <= pwdata[1:0];
                bni_pkg::REG_CODE_COLOR_3: cfg_reg.code_color_3 <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bni_pkg::REG_FRAME_WIDTH:  prdata = 32'(cfg_reg.frame_width);
            bni_pkg::REG_FRAME_HEIGHT: prdata = 32'(cfg_reg.frame_height);
            bni_pkg::REG_SEARCH_STEPS: prdata = 32'(cfg_reg.search_steps);
            bni_pkg::REG_CODE_COLOR_0: prdata = 32'(cfg_reg.code_color_0);
            bni_pkg::REG_CODE_COLOR_1: prdata = 32'(cfg_reg.code_color_1);
            bni_pkg::REG_CODE_COLOR_2: prdata = 32'(cfg_reg.code_color_2);
            bni_pkg::REG_CODE_COLOR_3: prdata = 32'(cfg_reg.code_color_3);
            default:                   prdata = '0;
        endcase
    end

    bni_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bni_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SEARCH (MAX_SEARCH)
    ) u_dp (
        .aclk     (aclk),
        .cfg      (cfg_reg),
        .in_col   (s_tdata[5:0]),
        .in_row   (s_tdata[11:6]),
        .in_raw   (s_tdata[27:12]),
        .in_code  (s_tdata[29:28]),
        .cmd      (cmd),
        .status   (status),
        .out_data (m_tdata)
    );

endmodule

@@ src/bni_ctrl.sv @@
// ----------------------------------------------------------------------------
// bni_ctrl
// sequencer for stores, neighbor averaging, directional search and division
// ----------------------------------------------------------------------------
module bni_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  bni_pkg::dp_status_t status,
    output bni_pkg::ctrl_cmd_t  cmd
);

    localparam logic [bni_pkg::STATE_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [bni_pkg::STATE_W-1:0] ST_START  = 4'd1;
    localparam logic [bni_pkg::STATE_W-1:0] ST_CINIT  = 4'd2;
    localparam logic [bni_pkg::STATE_W-1:0] ST_NBCHK  = 4'd3;
    localparam logic [bni_pkg::STATE_W-1:0] ST_NBRD   = 4'd4;
    localparam logic [bni_pkg::STATE_W-1:0] ST_NBEV   = 4'd5;
    localparam logic [bni_pkg::STATE_W-1:0] ST_NBNXT  = 4'd6;
    localparam logic [bni_pkg::STATE_W-1:0] ST_DRCHK  = 4'd7;
    localparam logic [bni_pkg::STATE_W-1:0] ST_DRRD   = 4'd8;
    localparam logic [bni_pkg::STATE_W-1:0] ST_DREV   = 4'd9;
    localparam logic [bni_pkg::STATE_W-1:0] ST_DRACC  = 4'd10;
    localparam logic [bni_pkg::STATE_W-1:0] ST_DRNXT  = 4'd11;
    localparam logic [bni_pkg::STATE_W-1:0] ST_DIV    = 4'd12;
    localparam logic [bni_pkg::STATE_W-1:0] ST_DIVEND = 4'd13;
    localparam logic [bni_pkg::STATE_W-1:0] ST_CNXT   = 4'd14;
    localparam logic [bni_pkg::STATE_W-1:0] ST_OUT    = 4'd15;

    logic [bni_pkg::STATE_W-1:0] state_reg, state_next;
    logic                        m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == bni_pkg::CMD_QUERY) begin
                        cmd.load   = 1'b1;
                        state_next = ST_START;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_START: begin
                if (status.outside) begin
                    cmd.all_zero = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT: begin
                cmd.clr_init = 1'b1;
                state_next   = ST_NBCHK;
            end
            ST_NBCHK: state_next = status.in_frame ? ST_NBRD : ST_NBNXT;
            ST_NBRD: begin
                cmd.read   = 1'b1;
                state_next = ST_NBEV;
            end
            ST_NBEV: begin
                cmd.nb_acc = 1'b1;
                state_next = ST_NBNXT;
            end
            ST_NBNXT: begin
                if (!status.nb_last) begin
                    cmd.nb_next = 1'b1;
                    state_next  = ST_NBCHK;
                end else if (!status.cnt_zero) begin
                    cmd.div_avg = 1'b1;
                    state_next  = ST_DIV;
                end else begin
                    cmd.dir_init = 1'b1;
                    state_next   = ST_DRCHK;
                end
            end
            ST_DRCHK: begin
                if (status.step_over || !status.in_frame) begin
                    state_next = ST_DRNXT;
                end else begin
                    state_next = ST_DRRD;
                end
            end
            ST_DRRD: begin
                cmd.read   = 1'b1;
                state_next = ST_DREV;
            end
            ST_DREV: begin
                if (status.match) begin
                    cmd.mul    = 1'b1;
                    state_next = ST_DRACC;
                end else begin
                    cmd.dir_step = 1'b1;
                    state_next   = ST_DRCHK;
                end
            end
            ST_DRACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_DRNXT;
            end
            ST_DRNXT: begin
                if (!status.dir_last) begin
                    cmd.dir_next = 1'b1;
                    state_next   = ST_DRCHK;
                end else if (status.den_zero) begin
                    cmd.zero_res = 1'b1;
                    state_next   = ST_CNXT;
                end else begin
                    cmd.div_wgt = 1'b1;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_DIVEND;
                end
            end
            ST_DIVEND: begin
                cmd.div_store = 1'b1;
                state_next    = ST_CNXT;
            end
            ST_CNXT: begin
                if (status.clr_last) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.clr_next = 1'b1;
                    state_next   = ST_CINIT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

@@ src/bni_dp.sv @@
// ----------------------------------------------------------------------------
// bni_dp
// frame memory, probe walker, weight accumulators and restoring divider
// ----------------------------------------------------------------------------
module bni_dp #(
    parameter int MAX_WIDTH  = bni_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bni_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_SEARCH = bni_pkg::MAX_SEARCH_DEF
) (
    input  logic                           aclk,
    input  bni_pkg::cfg_t                  cfg,
    input  logic [bni_pkg::POS_W-1:0]      in_col,
    input  logic [bni_pkg::POS_W-1:0]      in_row,
    input  logic [bni_pkg::SAMPLE_W-1:0]   in_raw,
    input  logic [bni_pkg::CODE_W-1:0]     in_code,
    input  bni_pkg::ctrl_cmd_t             cmd,
    output bni_pkg::dp_status_t            status,
    output logic [3*bni_pkg::SAMPLE_W-1:0] out_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WORD_W = bni_pkg::SAMPLE_W + bni_pkg::CODE_W;

    logic [WORD_W-1:0] mem [DEPTH];

    logic [bni_pkg::POS_W-1:0]          col_reg, row_reg;
    logic [1:0]                         clr_reg;
    logic [bni_pkg::IDX_W-1:0]          idx_reg;
    logic [bni_pkg::STEP_W-1:0]         step_reg;
    logic signed [bni_pkg::COORD_W-1:0] cur_c_reg, cur_r_reg;
    logic [WORD_W-1:0]                  rd_reg;
    logic [bni_pkg::SUM_W-1:0]          sum_reg;
    logic [bni_pkg::CNT_W-1:0]          cnt_reg;
    logic [bni_pkg::PROD_W-1:0]         prod_reg;
    logic [bni_pkg::NUM_W-1:0]          wnum_reg, dnum_reg;
    logic [bni_pkg::DEN_W-1:0]          wden_reg, dden_reg, rem_reg;
    logic [bni_pkg::DCNT_W-1:0]         dcnt_reg;
    logic [bni_pkg::SAMPLE_W-1:0]       res_reg [3];
    logic [3*bni_pkg::SAMPLE_W-1:0]     out_reg;

    logic [bni_pkg::DIM_W-1:0]          eff_w, eff_h;
    logic [bni_pkg::STEP_W-1:0]         eff_steps;
    logic signed [bni_pkg::COORD_W-1:0] col_ext, row_ext;
    logic [bni_pkg::IDX_W-1:0]          idx_inc;
    logic [AW-1:0]                      wr_addr, rd_addr;
    logic                               store_ok;
    logic [1:0]                         rd_color;
    logic [bni_pkg::DEN_W:0]            trial;
    logic                               trial_ge;
    logic [bni_pkg::WGT_W-1:0]          weight;

    assign eff_w = (int'(cfg.frame_width) > MAX_WIDTH) ? bni_pkg::DIM_W'(MAX_WIDTH)
                                                     : cfg.frame_width;
    assign eff_h = (int'(cfg.frame_height) > MAX_HEIGHT) ? bni_pkg::DIM_W'(MAX_HEIGHT)
                                                       : cfg.frame_height;
    assign eff_steps = (int'(cfg.search_steps) > MAX_SEARCH)
                     ? bni_pkg::STEP_W'(MAX_SEARCH) : {1'b0, cfg.search_steps};

    assign col_ext = bni_pkg::COORD_W'(col_reg);
    assign row_ext = bni_pkg::COORD_W'(row_reg);
    assign idx_inc = idx_reg + 1'b1;
    assign weight  = bni_pkg::step_weight(step_reg);

    assign store_ok = (int'(in_col) < MAX_WIDTH) && (int'(in_row) < MAX_HEIGHT);
    assign wr_addr  = AW'(int'(in_row) * MAX_WIDTH + int'(in_col));
    assign rd_addr  = AW'(int'(cur_r_reg[bni_pkg::DIM_W-1:0]) * MAX_WIDTH
                          + int'(cur_c_reg[bni_pkg::DIM_W-1:0]));

    always_comb begin
        case (rd_reg[WORD_W-1 -: bni_pkg::CODE_W])
            2'd0:    rd_color = cfg.code_color_0;
            2'd1:    rd_color = cfg.code_color_1;
            2'd2:    rd_color = cfg.code_color_2;
            default: rd_color = cfg.code_color_3;
        endcase
    end

    assign trial    = {rem_reg, dnum_reg[bni_pkg::NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, dden_reg});

    assign status.outside   = ({1'b0, col_reg} >= eff_w) || ({1'b0, row_reg} >= eff_h);
    assign status.in_frame  = !cur_c_reg[bni_pkg::COORD_W-1] && !cur_r_reg[bni_pkg::COORD_W-1]
                              && (cur_c_reg[bni_pkg::DIM_W-1:0] < eff_w)
                              && (cur_r_reg[bni_pkg::DIM_W-1:0] < eff_h);
    assign status.match     = (rd_color == clr_reg);
    assign status.nb_last   = (idx_reg == 3'd3);
    assign status.dir_last  = (idx_reg == 3'd7);
    assign status.cnt_zero  = (cnt_reg == '0);
    assign status.den_zero  = (wden_reg == '0);
    assign status.step_over = (step_reg > eff_steps);
    assign status.div_last  = (dcnt_reg == bni_pkg::DCNT_W'(bni_pkg::NUM_W - 1));
    assign status.clr_last  = (clr_reg == bni_pkg::COLOR_BLUE);

    assign out_data = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.write && store_ok) begin
            mem[wr_addr] <= {in_code, in_raw};
        end
        if (cmd.read) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            col_reg <= in_col;
            row_reg <= in_row;
            clr_reg <= '0;
        end
        if (cmd.clr_next) begin
            clr_reg <= clr_reg + 1'b1;
        end
        if (cmd.all_zero) begin
            res_reg[0] <= '0;
            res_reg[1] <= '0;
            res_reg[2] <= '0;
        end
        if (cmd.clr_init) begin
            sum_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            cur_c_reg <= col_ext;
            cur_r_reg <= row_ext;
        end
        if (cmd.nb_next) begin
            idx_reg   <= idx_inc;
            cur_c_reg <= col_ext + bni_pkg::COORD_W'(idx_inc[0]);
            cur_r_reg <= row_ext + bni_pkg::COORD_W'(idx_inc[1]);
        end
        if (cmd.nb_acc && status.match) begin
            sum_reg <= sum_reg + bni_pkg::SUM_W'(rd_reg[bni_pkg::SAMPLE_W-1:0]);
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.dir_init) begin
            idx_reg   <= '0;
            step_reg  <= bni_pkg::STEP_W'(1);
            cur_c_reg <= col_ext + bni_pkg::dir_dc('0);
            cur_r_reg <= row_ext + bni_pkg::dir_dr('0);
            wnum_reg  <= '0;
            wden_reg  <= '0;
        end
        if (cmd.dir_step) begin
            step_reg  <= step_reg + 1'b1;
            cur_c_reg <= cur_c_reg + bni_pkg::dir_dc(idx_reg);
            cur_r_reg <= cur_r_reg + bni_pkg::dir_dr(idx_reg);
        end
        if (cmd.dir_next) begin
            idx_reg   <= idx_inc;
            step_reg  <= bni_pkg::STEP_W'(1);
            cur_c_reg <= col_ext + bni_pkg::dir_dc(idx_inc);
            cur_r_reg <= row_ext + bni_pkg::dir_dr(idx_inc);
        end
        if (cmd.mul) begin
            prod_reg <= rd_reg[bni_pkg::SAMPLE_W-1:0] * weight;
        end
        if (cmd.acc) begin
            wnum_reg <= wnum_reg + bni_pkg::NUM_W'(prod_reg);
            wden_reg <= wden_reg + bni_pkg::DEN_W'(weight);
        end
        if (cmd.div_avg) begin
            dnum_reg <= bni_pkg::NUM_W'(sum_reg);
            dden_reg <= bni_pkg::DEN_W'(cnt_reg);
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_wgt) begin
            dnum_reg <= wnum_reg;
            dden_reg <= wden_reg;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= trial_ge ? bni_pkg::DEN_W'(trial - {1'b0, dden_reg})
                                 : trial[bni_pkg::DEN_W-1:0];
            dnum_reg <= {dnum_reg[bni_pkg::NUM_W-2:0], trial_ge};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.div_store) begin
            res_reg[clr_reg] <= dnum_reg[bni_pkg::SAMPLE_W-1:0];
        end
        if (cmd.zero_res) begin
            res_reg[clr_reg] <= '0;
        end
        if (cmd.out_load) begin
            out_reg <= {res_reg[2], res_reg[1], res_reg[0]};
        end
    end

endmodule

@@ src/bni_checker.sv @@
// ----------------------------------------------------------------------------
// bni_checker
// port-level checks of the bayer neighbor interpolation block
// ----------------------------------------------------------------------------
module bni_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input taken right after a query beat");

    a_store_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("store beat produced a result");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind bayer_neighbor_interpolation bni_checker u_bni_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
